// ===== hdl/dfnr_pkg.sv =====
// shared types and constants of the frame-delta nibble run-length encoder
package dfnr_pkg;

  localparam int FRAME_PIXELS = 16384;
  localparam int IDX_W        = $clog2(FRAME_PIXELS);

  localparam int PIXEL_W  = 16;
  localparam int NIB_W    = 4;
  localparam int NIB_LSB  = 12;
  localparam int CODE_W   = 8;
  localparam int PERIOD_W = 7;
  localparam int PHASE_W  = 6;

  localparam logic [NIB_W-1:0]    RUN_MAX      = 4'd15;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 7'd64;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd6;

  localparam int QUEUE_DEPTH = 2;

  // one classified pixel on its way from front to back
  typedef struct packed {
    logic [NIB_W-1:0] sym;
    logic             key;
    logic             last;
  } sym_item_t;

  // one output code beat
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              key_frame;
    logic              last;
  } code_t;

endpackage

// ===== hdl/delta_frame_nibble_rle_encoder.sv =====
// Frame-delta nibble run-length encoder, top level. One pixel is taken per clock unless
// the input is stalled. The front stage reads and rewrites the 16384 x 4 previous-frame
// ram in the cycle a pixel is taken and forms its symbol in the cycle after, a two-entry
// queue carries symbols to the run-length back end, and a code reaches the output register
// once the pixel closing its run has passed the symbol register and the queue, behind any
// symbols waiting there. The back end takes one symbol per clock unless the output is
// stalled, except that the last pixel of a frame whose run is also closed by a symbol
// change or a full count produces two codes, the second kept pending until the first has
// left, holding the back end; the queue absorbs it, and the input stalls only if the queue
// is full. The ram has one read and one write port and needs no clearing pass after reset:
// the first frame is always a key frame, writes every entry and ignores what it reads.
module delta_frame_nibble_rle_encoder import dfnr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [PERIOD_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PIXEL_W-1:0]  pixel_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CODE_W-1:0]   code_o,
  output logic                key_frame_o,
  output logic                last_o
);

  logic      push;
  sym_item_t push_item;
  logic      full;
  logic      pop;
  logic      empty;
  sym_item_t pop_item;

  dfnr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_i    (pixel_i),
    .push_o     (push),
    .push_item_o(push_item),
    .full_i     (full)
  );

  dfnr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_item_o (pop_item)
  );

  dfnr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .item_i     (pop_item),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .code_o     (code_o),
    .key_frame_o(key_frame_o),
    .last_o     (last_o)
  );

endmodule

// ===== hdl/dfnr_ram.sv =====
// generic single-write, single-read ram with registered read data
module dfnr_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // same-address read returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hdl/dfnr_front.sv =====
// front: pixel intake, frame position, key/delta choice and previous-frame store
module dfnr_front import dfnr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [PERIOD_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PIXEL_W-1:0]  pixel_i,
  output logic                push_o,
  output sym_item_t           push_item_o,
  input  logic                full_i
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_PIXELS - 1);

  logic [PERIOD_W-1:0] period_q;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic                s1_valid_q, s1_valid_d;
  logic [NIB_W-1:0]    s1_nib_q;
  logic                s1_key_q;
  logic                s1_last_q;
  logic [NIB_W-1:0]    prev_nib;
  logic [NIB_W-1:0]    nib;
  logic                accept;
  logic                at_last;
  logic [PERIOD_W-1:0] period_eff;
  logic [PERIOD_W-1:0] phase_inc;

  assign nib     = pixel_i[NIB_LSB +: NIB_W];
  assign at_last = (idx_q == LAST_IDX);

  assign push_o     = s1_valid_q && !full_i;
  assign in_stall_o = s1_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign push_item_o.sym  = s1_key_q ? s1_nib_q : (s1_nib_q - prev_nib);
  assign push_item_o.key  = s1_key_q;
  assign push_item_o.last = s1_last_q;

  dfnr_ram #(
    .WIDTH(NIB_W),
    .DEPTH(FRAME_PIXELS)
  ) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(idx_q),
    .wdata_i(nib),
    .re_i   (accept),
    .raddr_i(idx_q),
    .rdata_o(prev_nib)
  );

  always_comb begin
    if (period_q == '0) begin
      period_eff = PERIOD_W'(1);
    end else if (period_q > PERIOD_MAX) begin
      period_eff = PERIOD_MAX;
    end else begin
      period_eff = period_q;
    end
  end

  assign phase_inc = {1'b0, phase_q} + PERIOD_W'(1);

  always_comb begin
    idx_d      = idx_q;
    phase_d    = phase_q;
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
      if (at_last) begin
        idx_d   = '0;
        phase_d = (phase_inc >= period_eff) ? '0 : phase_inc[PHASE_W-1:0];
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_RESET;
      idx_q      <= '0;
      phase_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      idx_q      <= idx_d;
      phase_q    <= phase_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_nib_q  <= nib;
      s1_key_q  <= (phase_q == '0);
      s1_last_q <= at_last;
    end
  end

endmodule

// ===== hdl/dfnr_queue.sv =====
// short fifo of classified symbols between front and back
module dfnr_queue import dfnr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sym_item_t push_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output sym_item_t pop_item_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  sym_item_t        entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hdl/dfnr_back.sv =====
// back: run-length engine with output register and one pending code
module dfnr_back import dfnr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  sym_item_t         item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CODE_W-1:0] code_o,
  output logic              key_frame_o,
  output logic              last_o
);

  logic [NIB_W-1:0] run_sym_q, run_sym_d;
  logic [NIB_W-1:0] run_len_q, run_len_d;
  logic             out_valid_q, out_valid_d;
  logic             pend_valid_q, pend_valid_d;
  code_t            out_q, out_d;
  code_t            pend_q, pend_d;
  code_t            closed_code;
  code_t            final_code;
  logic             closes;
  logic [NIB_W-1:0] new_sym;
  logic [NIB_W-1:0] new_len;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  // pending code goes first, so no item is taken while it waits
  assign pop_o    = !empty_i && out_free && !pend_valid_q;

  assign closes = (run_len_q != '0) &&
                  ((run_len_q >= RUN_MAX) || (item_i.sym != run_sym_q));

  always_comb begin
    if ((run_len_q == '0) || closes) begin
      new_sym = item_i.sym;
      new_len = NIB_W'(1);
    end else begin
      new_sym = run_sym_q;
      new_len = run_len_q + NIB_W'(1);
    end
  end

  assign closed_code.code      = {run_sym_q, run_len_q};
  assign closed_code.key_frame = item_i.key;
  assign closed_code.last      = 1'b0;
  assign final_code.code       = {new_sym, new_len};
  assign final_code.key_frame  = item_i.key;
  assign final_code.last       = 1'b1;

  always_comb begin
    run_sym_d    = run_sym_q;
    run_len_d    = run_len_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (pend_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      pend_valid_d = 1'b0;
    end else if (pop_o) begin
      if (item_i.last) begin
        run_sym_d = '0;
        run_len_d = '0;
      end else begin
        run_sym_d = new_sym;
        run_len_d = new_len;
      end
      if (closes) begin
        out_valid_d = 1'b1;
        out_d       = closed_code;
        if (item_i.last) begin
          pend_valid_d = 1'b1;
          pend_d       = final_code;
        end
      end else if (item_i.last) begin
        out_valid_d = 1'b1;
        out_d       = final_code;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sym_q    <= '0;
      run_len_q    <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      run_sym_q    <= run_sym_d;
      run_len_q    <= run_len_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = out_q.code;
  assign key_frame_o = out_q.key_frame;
  assign last_o      = out_q.last;

endmodule

// ===== hdl/dfnr_checker.sv =====
// port-level checker of the encoder, bound to the top level
module dfnr_checker import dfnr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [CODE_W-1:0]   code_o,
  input logic                key_frame_o,
  input logic                last_o
);

  logic seen_q;
  logic prev_last_q;
  logic prev_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      prev_last_q <= 1'b0;
      prev_key_q  <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      seen_q      <= 1'b1;
      prev_last_q <= last_o;
      prev_key_q  <= key_frame_o;
    end
  end

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_o) &&
      $stable(key_frame_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  // run count is never zero
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> code_o[3:0] != 4'd0)
    else $error("code with zero run count");

  // codes inside one frame share the frame type
  a_frame_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q && !prev_last_q |-> key_frame_o == prev_key_q)
    else $error("frame type changed inside a frame");

  // nothing is offered downstream and nothing is stalled right after reset
  a_no_out_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("output or stall active right after reset");

endmodule

bind delta_frame_nibble_rle_encoder dfnr_checker u_dfnr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .code_o     (code_o),
  .key_frame_o(key_frame_o),
  .last_o     (last_o)
);

// ===== test/tb.sv =====
// testbench for the frame-delta nibble run-length encoder: random frames checked against a predictor
module tb;
  import dfnr_pkg::*;

  localparam int IDLE_PCT    = 36;
  localparam int SETTLE_CYC  = 16;
  localparam int STUCK_LIMIT = 5000;
  localparam int PRINT_LIMIT = 100;

  typedef enum {TAIL_RANDOM, TAIL_CHANGE, TAIL_FULL} frame_tail_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [PERIOD_W-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic [PIXEL_W-1:0]  pixel_i     = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [CODE_W-1:0]   code_o;
  logic                key_frame_o;
  logic                last_o;

  delta_frame_nibble_rle_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_o      (code_o),
    .key_frame_o (key_frame_o),
    .last_o      (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // pixels waiting for the driver and codes waiting for the monitor
  logic [PIXEL_W-1:0] pixel_q [$];
  code_t              code_q [$];

  // encoder state as the predictor sees it
  logic [NIB_W-1:0]    prev_nib [FRAME_PIXELS];
  logic [NIB_W-1:0]    run_sym     = '0;
  logic [NIB_W-1:0]    run_len     = '0;
  logic [IDX_W-1:0]    pix_idx     = '0;
  int unsigned         frame_phase = 0;
  logic [PERIOD_W-1:0] key_period  = PERIOD_RESET;

  // generator side: last frame's nibbles so delta frames can carry real runs
  logic [NIB_W-1:0] gen_prev_nib [FRAME_PIXELS];
  logic [IDX_W-1:0] gen_idx      = '0;
  logic [NIB_W-1:0] gen_last_sym = '0;

  int    errors     = 0;
  int    code_beats = 0;
  int    cyc        = 0;
  int    stuck      = 0;
  logic  calm;
  code_t got_want;

  // no idling on either side through one long stretch
  assign calm = (cyc >= 700) && (cyc < 1400);

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (errors < PRINT_LIMIT) begin
      $display("mismatch on %s at code beat %0d: expected %0h, got %0h",
               what, code_beats, want, got);
    end
    errors++;
  endtask

  function automatic void queue_code(input logic [NIB_W-1:0] sym, input logic [NIB_W-1:0] len,
                                     input logic key, input logic last);
    code_t c;
    c.code      = {sym, len};
    c.key_frame = key;
    c.last      = last;
    code_q.push_back(c);
  endfunction

  function automatic void encode_pixel(input logic [PIXEL_W-1:0] px);
    logic [NIB_W-1:0]    nib;
    logic [NIB_W-1:0]    sym;
    logic                key;
    logic [PERIOD_W-1:0] per;
    key = (frame_phase == 0);
    nib = px[NIB_LSB +: NIB_W];
    if (key) begin
      sym = nib;
    end else begin
      sym = nib - prev_nib[pix_idx];
    end
    prev_nib[pix_idx] = nib;
    if (run_len == 0) begin
      run_sym = sym;
      run_len = NIB_W'(1);
    end else if (run_len == RUN_MAX || sym != run_sym) begin
      queue_code(run_sym, run_len, key, 1'b0);
      run_sym = sym;
      run_len = NIB_W'(1);
    end else begin
      run_len = run_len + 1'b1;
    end
    if (pix_idx == IDX_W'(FRAME_PIXELS - 1)) begin
      queue_code(run_sym, run_len, key, 1'b1);
      run_sym = '0;
      run_len = '0;
      per = key_period;
      if (per == 0) begin
        per = PERIOD_W'(1);
      end else if (per > PERIOD_MAX) begin
        per = PERIOD_MAX;
      end
      // a lowered period wraps the phase back to a key frame
      if (frame_phase + 1 >= per) begin
        frame_phase = 0;
      end else begin
        frame_phase = frame_phase + 1;
      end
    end
    pix_idx = pix_idx + 1'b1;
  endfunction

  function automatic void add_pixel(input logic [PIXEL_W-1:0] px, input logic key);
    logic [NIB_W-1:0] nib;
    nib = px[NIB_LSB +: NIB_W];
    if (key) begin
      gen_last_sym = nib;
    end else begin
      gen_last_sym = nib - gen_prev_nib[gen_idx];
    end
    gen_prev_nib[gen_idx] = nib;
    gen_idx = gen_idx + 1'b1;
    pixel_q.push_back(px);
  endfunction

  // runs of random symbols and lengths, some pure noise, with a chosen frame ending
  task automatic push_pixels(input logic key, input int count, input frame_tail_e tail);
    logic [NIB_W-1:0]   sym;
    logic [NIB_W-1:0]   nib;
    logic [PIXEL_W-1:0] px;
    int                 left;
    bit                 noise;
    sym   = '0;
    left  = 0;
    noise = 1'b0;
    @(negedge clk_i);
    for (int i = 0; i < count; i++) begin
      if (tail == TAIL_FULL && gen_idx == IDX_W'(FRAME_PIXELS - 16)) begin
        // fresh run of 16: the full count closes on the last pixel of the frame
        sym   = gen_last_sym + 1'b1;
        noise = 1'b0;
        left  = 16;
      end else if (tail == TAIL_CHANGE && gen_idx == IDX_W'(FRAME_PIXELS - 1)) begin
        sym   = gen_last_sym + 1'b1;
        noise = 1'b0;
        left  = 1;
      end else if (left == 0) begin
        noise = ($urandom_range(99) < 20);
        sym   = NIB_W'($urandom);
        left  = ($urandom_range(9) == 0) ? 15 * $urandom_range(2, 1) : $urandom_range(18, 1);
      end
      left--;
      nib = key ? sym : sym + gen_prev_nib[gen_idx];
      px  = noise ? PIXEL_W'($urandom) : {nib, NIB_LSB'($urandom)};
      add_pixel(px, key);
    end
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || code_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    key_period = value;
  endtask

  // driver: holds a stalled beat, otherwise presents the next pixel or idles
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        encode_pixel(pixel_q.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid_i <= 1'b1;
          pixel_i    <= pixel_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure and field checks against the oldest expected code
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
      if (out_valid_o && !out_stall_i) begin
        if (code_q.size() == 0) begin
          report_mismatch("unexpected code", 0, code_o);
        end else begin
          got_want = code_q.pop_front();
          if (code_o !== got_want.code) begin
            report_mismatch("code", got_want.code, code_o);
          end
          if (key_frame_o !== got_want.key_frame) begin
            report_mismatch("key_frame", got_want.key_frame, key_frame_o);
          end
          if (last_o !== got_want.last) begin
            report_mismatch("last", got_want.last, last_o);
          end
        end
        code_beats++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc <= cyc + 1;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck <= 0;
      end else if (stuck >= STUCK_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stuck <= stuck + 1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // key frame at reset period: nibble extremes, a run past the full count, a change
    add_pixel(16'h0000, 1'b1);
    add_pixel(16'hFFFF, 1'b1);
    add_pixel(16'h0FFF, 1'b1);
    add_pixel(16'hF000, 1'b1);
    add_pixel(16'h7FFF, 1'b1);
    add_pixel(16'h8000, 1'b1);
    for (int i = 0; i < 16; i++) begin
      add_pixel({4'hA, NIB_LSB'($urandom)}, 1'b1);
    end
    add_pixel(16'h5A5A, 1'b1);
    push_pixels(1'b1, 800, TAIL_RANDOM);

    // period writes inside a frame only count at its end
    wait_drained();
    write_period(7'd127);
    push_pixels(1'b1, 400, TAIL_RANDOM);

    wait_drained();
    write_period(7'd0);
    push_pixels(1'b1, 377, TAIL_RANDOM);
    wait_drained();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dfnr_pkg.sv
hdl/dfnr_ram.sv
hdl/dfnr_front.sv
hdl/dfnr_queue.sv
hdl/dfnr_back.sv
hdl/delta_frame_nibble_rle_encoder.sv
hdl/dfnr_checker.sv
test/tb.sv
